>>> rtl/psid_pkg.sv
// ----------------------------------------------------------------------------
// psid_pkg
// Types and constants shared by the paired-single instruction decoder.
// ----------------------------------------------------------------------------
package psid_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned CODE_W = 6;
  localparam int unsigned FORM_W = 3;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned DISP_W = 12;

  // primary opcodes
  localparam logic [5:0] OP_PS     = 6'd4;
  localparam logic [5:0] OP_PSQ_L  = 6'd56;
  localparam logic [5:0] OP_PSQ_LU = 6'd57;
  localparam logic [5:0] OP_PSQ_ST = 6'd60;
  localparam logic [5:0] OP_PSQ_STU = 6'd61;

  // 10-bit extended opcodes
  localparam logic [9:0] XO_MERGE00 = 10'd528;
  localparam logic [9:0] XO_MERGE01 = 10'd560;
  localparam logic [9:0] XO_MERGE10 = 10'd592;
  localparam logic [9:0] XO_MERGE11 = 10'd624;
  localparam logic [9:0] XO_NEG     = 10'd40;
  localparam logic [9:0] XO_MR      = 10'd72;
  localparam logic [9:0] XO_NABS    = 10'd136;
  localparam logic [9:0] XO_ABS     = 10'd264;
  localparam logic [9:0] XO_CMPU0   = 10'd0;
  localparam logic [9:0] XO_CMPO0   = 10'd32;
  localparam logic [9:0] XO_CMPU1   = 10'd64;
  localparam logic [9:0] XO_CMPO1   = 10'd96;

  // 5-bit extended opcodes
  localparam logic [4:0] XO_DIV    = 5'd18;
  localparam logic [4:0] XO_SUB    = 5'd20;
  localparam logic [4:0] XO_ADD    = 5'd21;
  localparam logic [4:0] XO_RES    = 5'd24;
  localparam logic [4:0] XO_RSQRTE = 5'd26;
  localparam logic [4:0] XO_MULS0  = 5'd12;
  localparam logic [4:0] XO_MULS1  = 5'd13;
  localparam logic [4:0] XO_MUL    = 5'd25;
  localparam logic [4:0] XO_SUM0   = 5'd10;
  localparam logic [4:0] XO_SUM1   = 5'd11;
  localparam logic [4:0] XO_MADDS0 = 5'd14;
  localparam logic [4:0] XO_MADDS1 = 5'd15;
  localparam logic [4:0] XO_SEL    = 5'd23;
  localparam logic [4:0] XO_MSUB   = 5'd28;
  localparam logic [4:0] XO_MADD   = 5'd29;
  localparam logic [4:0] XO_NMSUB  = 5'd30;
  localparam logic [4:0] XO_NMADD  = 5'd31;

  // operand forms
  localparam logic [FORM_W-1:0] FORM_NONE  = 3'd0;
  localparam logic [FORM_W-1:0] FORM_QUANT = 3'd1;
  localparam logic [FORM_W-1:0] FORM_DAB   = 3'd2;
  localparam logic [FORM_W-1:0] FORM_DAC   = 3'd3;
  localparam logic [FORM_W-1:0] FORM_DB    = 3'd4;
  localparam logic [FORM_W-1:0] FORM_DACB  = 3'd5;

  // instruction codes
  localparam logic [CODE_W-1:0] I_PSQ_L     = 6'd0;
  localparam logic [CODE_W-1:0] I_PSQ_LU    = 6'd1;
  localparam logic [CODE_W-1:0] I_PSQ_ST    = 6'd2;
  localparam logic [CODE_W-1:0] I_PSQ_STU   = 6'd3;
  localparam logic [CODE_W-1:0] I_MERGE00   = 6'd4;
  localparam logic [CODE_W-1:0] I_MERGE01   = 6'd5;
  localparam logic [CODE_W-1:0] I_MERGE10   = 6'd6;
  localparam logic [CODE_W-1:0] I_MERGE11   = 6'd7;
  localparam logic [CODE_W-1:0] I_NEG       = 6'd8;
  localparam logic [CODE_W-1:0] I_MR        = 6'd9;
  localparam logic [CODE_W-1:0] I_NABS      = 6'd10;
  localparam logic [CODE_W-1:0] I_ABS       = 6'd11;
  localparam logic [CODE_W-1:0] I_CMPU0     = 6'd12;
  localparam logic [CODE_W-1:0] I_DIV       = 6'd16;
  localparam logic [CODE_W-1:0] I_SUB       = 6'd17;
  localparam logic [CODE_W-1:0] I_ADD       = 6'd18;
  localparam logic [CODE_W-1:0] I_RES       = 6'd19;
  localparam logic [CODE_W-1:0] I_RSQRTE    = 6'd20;
  localparam logic [CODE_W-1:0] I_MULS0     = 6'd21;
  localparam logic [CODE_W-1:0] I_MULS1     = 6'd22;
  localparam logic [CODE_W-1:0] I_MUL       = 6'd23;
  localparam logic [CODE_W-1:0] I_SUM0      = 6'd24;
  localparam logic [CODE_W-1:0] I_SUM1      = 6'd25;
  localparam logic [CODE_W-1:0] I_MADDS0    = 6'd26;
  localparam logic [CODE_W-1:0] I_MADDS1    = 6'd27;
  localparam logic [CODE_W-1:0] I_SEL       = 6'd28;
  localparam logic [CODE_W-1:0] I_MSUB      = 6'd29;
  localparam logic [CODE_W-1:0] I_MADD      = 6'd30;
  localparam logic [CODE_W-1:0] I_NMSUB     = 6'd31;
  localparam logic [CODE_W-1:0] I_NMADD     = 6'd32;

  typedef struct packed {
    logic                     recognized;
    logic [CODE_W-1:0]        insn_code;
    logic [FORM_W-1:0]        operand_form;
    logic                     compare_form;
    logic [CNT_W-1:0]         operand_count;
    logic [REG_W-1:0]         operand_zero;
    logic [REG_W-1:0]         operand_one;
    logic [REG_W-1:0]         operand_two;
    logic [REG_W-1:0]         operand_three;
    logic signed [DISP_W-1:0] displacement;
  } decode_t;

endpackage

>>> rtl/paired_single_insn_decoder_unit.sv
// ----------------------------------------------------------------------------
// paired_single_insn_decoder_unit
// Paired-single instruction decoder with registered input and result.
// ----------------------------------------------------------------------------
// One instruction word is taken per cycle while word_stall is low. A word
// is held in the input register, decoded by the opcode decode, and its
// decoded result is presented from the result register, where a stalled
// result holds while the input register can still take one further word
// if it is empty.
module paired_single_insn_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 word_valid,
  output logic                                 word_stall,
  input  logic [psid_pkg::WORD_W-1:0]          instruction_word,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 recognized,
  output logic [psid_pkg::CODE_W-1:0]          insn_code,
  output logic [psid_pkg::FORM_W-1:0]          operand_form,
  output logic                                 compare_form,
  output logic [psid_pkg::CNT_W-1:0]           operand_count,
  output logic [psid_pkg::REG_W-1:0]           operand_zero,
  output logic [psid_pkg::REG_W-1:0]           operand_one,
  output logic [psid_pkg::REG_W-1:0]           operand_two,
  output logic [psid_pkg::REG_W-1:0]           operand_three,
  output logic signed [psid_pkg::DISP_W-1:0]   displacement
);

  logic                        held_valid;
  logic [psid_pkg::WORD_W-1:0] held_word;
  logic                        advance;
  psid_pkg::decode_t           decoded;
  psid_pkg::decode_t           result;

  assign advance    = !result_valid || !result_stall;
  assign word_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!word_stall) begin
      held_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!word_stall) begin
      held_word <= instruction_word;
    end
  end

  psid_decode u_decode (
    .word   (held_word),
    .result (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      result <= decoded;
    end
  end

  assign recognized    = result.recognized;
  assign insn_code     = result.insn_code;
  assign operand_form  = result.operand_form;
  assign compare_form  = result.compare_form;
  assign operand_count = result.operand_count;
  assign operand_zero  = result.operand_zero;
  assign operand_one   = result.operand_one;
  assign operand_two   = result.operand_two;
  assign operand_three = result.operand_three;
  assign displacement  = result.displacement;

  a_unrecognised_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !recognized) |->
      (insn_code == '0 && operand_form == psid_pkg::FORM_NONE && operand_count == '0))
    else $error("unrecognised transaction carries non-zero fields");

  a_count_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && recognized) |->
      ((operand_form == psid_pkg::FORM_DB) == (operand_count == 3'd2)))
    else $error("operand count disagrees with form");

  a_disp_quant: assert property (@(posedge clk) disable iff (rst)
    (result_valid && displacement != '0) |-> (operand_form == psid_pkg::FORM_QUANT))
    else $error("displacement outside quantised form");

  a_cmp_crf: assert property (@(posedge clk) disable iff (rst)
    (result_valid && compare_form) |->
      (operand_zero[4:3] == 2'd0 && operand_form == psid_pkg::FORM_DAB))
    else $error("compare transaction with bad field");

  a_held_advance: assert property (@(posedge clk) disable iff (rst)
    (held_valid && advance) |=> result_valid)
    else $error("held transaction dropped");

endmodule

>>> rtl/psid_decode.sv
// ----------------------------------------------------------------------------
// psid_decode
// Combinational decode of one instruction word into code, form and operands.
// ----------------------------------------------------------------------------
module psid_decode (
  input  logic [psid_pkg::WORD_W-1:0] word,
  output psid_pkg::decode_t           result
);

  logic [5:0]                    primary;
  logic [psid_pkg::REG_W-1:0]    fd;
  logic [psid_pkg::REG_W-1:0]    fa;
  logic [psid_pkg::REG_W-1:0]    fb;
  logic [psid_pkg::REG_W-1:0]    fc;
  logic [9:0]                    xo10;
  logic [4:0]                    xo5;
  logic                          hit10;
  logic                          is_cmp;
  logic [psid_pkg::CODE_W-1:0]   code10;
  logic [psid_pkg::FORM_W-1:0]   form10;
  logic                          hit5;
  logic [psid_pkg::CODE_W-1:0]   code5;
  logic [psid_pkg::FORM_W-1:0]   form5;
  logic [psid_pkg::CODE_W-1:0]   code_sel;
  logic [psid_pkg::FORM_W-1:0]   form_sel;

  assign primary = word[31:26];
  assign fd      = word[25:21];
  assign fa      = word[20:16];
  assign fb      = word[15:11];
  assign fc      = word[10:6];
  assign xo10    = word[10:1];
  assign xo5     = word[5:1];

  always_comb begin
    hit10  = 1'b1;
    is_cmp = 1'b0;
    code10 = '0;
    form10 = psid_pkg::FORM_DAB;
    case (xo10)
      psid_pkg::XO_MERGE00: code10 = psid_pkg::I_MERGE00;
      psid_pkg::XO_MERGE01: code10 = psid_pkg::I_MERGE01;
      psid_pkg::XO_MERGE10: code10 = psid_pkg::I_MERGE10;
      psid_pkg::XO_MERGE11: code10 = psid_pkg::I_MERGE11;
      psid_pkg::XO_NEG: begin
        code10 = psid_pkg::I_NEG;
        form10 = psid_pkg::FORM_DB;
      end
      psid_pkg::XO_MR: begin
        code10 = psid_pkg::I_MR;
        form10 = psid_pkg::FORM_DB;
      end
      psid_pkg::XO_NABS: begin
        code10 = psid_pkg::I_NABS;
        form10 = psid_pkg::FORM_DB;
      end
      psid_pkg::XO_ABS: begin
        code10 = psid_pkg::I_ABS;
        form10 = psid_pkg::FORM_DB;
      end
      psid_pkg::XO_CMPU0, psid_pkg::XO_CMPO0, psid_pkg::XO_CMPU1, psid_pkg::XO_CMPO1: begin
        is_cmp = 1'b1;
        code10 = psid_pkg::I_CMPU0 + {4'd0, xo10[6:5]};
      end
      default: hit10 = 1'b0;
    endcase
  end

  always_comb begin
    hit5  = 1'b1;
    code5 = '0;
    form5 = psid_pkg::FORM_DACB;
    case (xo5)
      psid_pkg::XO_DIV: begin
        code5 = psid_pkg::I_DIV;
        form5 = psid_pkg::FORM_DAB;
      end
      psid_pkg::XO_SUB: begin
        code5 = psid_pkg::I_SUB;
        form5 = psid_pkg::FORM_DAB;
      end
      psid_pkg::XO_ADD: begin
        code5 = psid_pkg::I_ADD;
        form5 = psid_pkg::FORM_DAB;
      end
      psid_pkg::XO_RES: begin
        code5 = psid_pkg::I_RES;
        form5 = psid_pkg::FORM_DB;
      end
      psid_pkg::XO_RSQRTE: begin
        code5 = psid_pkg::I_RSQRTE;
        form5 = psid_pkg::FORM_DB;
      end
      psid_pkg::XO_MULS0: begin
        code5 = psid_pkg::I_MULS0;
        form5 = psid_pkg::FORM_DAC;
      end
      psid_pkg::XO_MULS1: begin
        code5 = psid_pkg::I_MULS1;
        form5 = psid_pkg::FORM_DAC;
      end
      psid_pkg::XO_MUL: begin
        code5 = psid_pkg::I_MUL;
        form5 = psid_pkg::FORM_DAC;
      end
      psid_pkg::XO_SUM0:   code5 = psid_pkg::I_SUM0;
      psid_pkg::XO_SUM1:   code5 = psid_pkg::I_SUM1;
      psid_pkg::XO_MADDS0: code5 = psid_pkg::I_MADDS0;
      psid_pkg::XO_MADDS1: code5 = psid_pkg::I_MADDS1;
      psid_pkg::XO_SEL:    code5 = psid_pkg::I_SEL;
      psid_pkg::XO_MSUB:   code5 = psid_pkg::I_MSUB;
      psid_pkg::XO_MADD:   code5 = psid_pkg::I_MADD;
      psid_pkg::XO_NMSUB:  code5 = psid_pkg::I_NMSUB;
      psid_pkg::XO_NMADD:  code5 = psid_pkg::I_NMADD;
      default:             hit5  = 1'b0;
    endcase
  end

  assign code_sel = hit10 ? code10 : code5;
  assign form_sel = hit10 ? form10 : form5;

  always_comb begin
    result = '0;
    case (primary)
      psid_pkg::OP_PSQ_L, psid_pkg::OP_PSQ_LU, psid_pkg::OP_PSQ_ST, psid_pkg::OP_PSQ_STU: begin
        result.recognized    = 1'b1;
        result.insn_code     = {3'd0, primary[2], primary[0]} + psid_pkg::I_PSQ_L;
        result.operand_form  = psid_pkg::FORM_QUANT;
        result.operand_count = 3'd4;
        result.operand_zero  = fd;
        result.operand_one   = fa;
        result.operand_two   = {4'd0, word[15]};
        result.operand_three = {2'd0, word[14:12]};
        result.displacement  = word[11:0];
      end
      psid_pkg::OP_PS: begin
        if (hit10 || hit5) begin
          result.recognized   = 1'b1;
          result.insn_code    = code_sel;
          result.operand_form = form_sel;
          result.operand_zero = fd;
          if (hit10 && is_cmp) begin
            result.compare_form  = 1'b1;
            result.operand_count = 3'd3;
            result.operand_zero  = {2'd0, word[25:23]};
            result.operand_one   = fa;
            result.operand_two   = fb;
          end else begin
            case (form_sel)
              psid_pkg::FORM_DAB: begin
                result.operand_count = 3'd3;
                result.operand_one   = fa;
                result.operand_two   = fb;
              end
              psid_pkg::FORM_DAC: begin
                result.operand_count = 3'd3;
                result.operand_one   = fa;
                result.operand_two   = fc;
              end
              psid_pkg::FORM_DB: begin
                result.operand_count = 3'd2;
                result.operand_one   = fb;
              end
              default: begin
                result.operand_count = 3'd4;
                result.operand_one   = fa;
                result.operand_two   = fc;
                result.operand_three = fb;
              end
            endcase
          end
        end
      end
      default: result = '0;
    endcase
  end

endmodule

>>> tb/sv/tb_paired_single_insn_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paired_single_insn_decoder_unit
// Self-checking bench for the paired-single instruction decoder. Directed
// words cover every instruction, the field extremes and the unrecognised
// cases. Random streams of well-formed and raw words follow, with the
// sender and the receiver idling at random in all but the last stream. Each
// word's decode is predicted on acceptance and compared field by field with
// the result transaction.
module tb_paired_single_insn_decoder_unit;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               word_valid = 1'b0;
  logic                               word_stall;
  logic [psid_pkg::WORD_W-1:0]        instruction_word = '0;
  logic                               result_valid;
  logic                               result_stall = 1'b0;
  logic                               recognized;
  logic [psid_pkg::CODE_W-1:0]        insn_code;
  logic [psid_pkg::FORM_W-1:0]        operand_form;
  logic                               compare_form;
  logic [psid_pkg::CNT_W-1:0]         operand_count;
  logic [psid_pkg::REG_W-1:0]         operand_zero;
  logic [psid_pkg::REG_W-1:0]         operand_one;
  logic [psid_pkg::REG_W-1:0]         operand_two;
  logic [psid_pkg::REG_W-1:0]         operand_three;
  logic signed [psid_pkg::DISP_W-1:0] displacement;

  psid_pkg::decode_t pending_decodes[$];
  psid_pkg::decode_t want;
  int                sender_idle_pct = 0;
  int                receiver_stall_pct = 0;
  int                mismatch_count = 0;
  int                words_sent = 0;
  int                results_seen = 0;
  int                recognised_seen = 0;

  paired_single_insn_decoder_unit dut (
    .clk              (clk),
    .rst              (rst),
    .word_valid       (word_valid),
    .word_stall       (word_stall),
    .instruction_word (instruction_word),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .recognized       (recognized),
    .insn_code        (insn_code),
    .operand_form     (operand_form),
    .compare_form     (compare_form),
    .operand_count    (operand_count),
    .operand_zero     (operand_zero),
    .operand_one      (operand_one),
    .operand_two      (operand_two),
    .operand_three    (operand_three),
    .displacement     (displacement)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [5:0] quant_opcode(input int idx);
    case (idx)
      0: return psid_pkg::OP_PSQ_L;
      1: return psid_pkg::OP_PSQ_LU;
      2: return psid_pkg::OP_PSQ_ST;
      default: return psid_pkg::OP_PSQ_STU;
    endcase
  endfunction

  function automatic logic [9:0] ten_bit_opcode(input int idx);
    case (idx)
      0: return psid_pkg::XO_MERGE00;
      1: return psid_pkg::XO_MERGE01;
      2: return psid_pkg::XO_MERGE10;
      3: return psid_pkg::XO_MERGE11;
      4: return psid_pkg::XO_NEG;
      5: return psid_pkg::XO_MR;
      6: return psid_pkg::XO_NABS;
      7: return psid_pkg::XO_ABS;
      8: return psid_pkg::XO_CMPU0;
      9: return psid_pkg::XO_CMPO0;
      10: return psid_pkg::XO_CMPU1;
      default: return psid_pkg::XO_CMPO1;
    endcase
  endfunction

  function automatic logic [4:0] five_bit_opcode(input int idx);
    case (idx)
      0: return psid_pkg::XO_DIV;
      1: return psid_pkg::XO_SUB;
      2: return psid_pkg::XO_ADD;
      3: return psid_pkg::XO_RES;
      4: return psid_pkg::XO_RSQRTE;
      5: return psid_pkg::XO_MULS0;
      6: return psid_pkg::XO_MULS1;
      7: return psid_pkg::XO_MUL;
      8: return psid_pkg::XO_SUM0;
      9: return psid_pkg::XO_SUM1;
      10: return psid_pkg::XO_MADDS0;
      11: return psid_pkg::XO_MADDS1;
      12: return psid_pkg::XO_SEL;
      13: return psid_pkg::XO_MSUB;
      14: return psid_pkg::XO_MADD;
      15: return psid_pkg::XO_NMSUB;
      default: return psid_pkg::XO_NMADD;
    endcase
  endfunction

  function automatic logic [psid_pkg::WORD_W-1:0] quant_word(input logic [5:0] op,
      input logic [4:0] rd, input logic [4:0] ra, input logic wbit,
      input logic [2:0] gqr, input logic [11:0] disp);
    return {op, rd, ra, wbit, gqr, disp};
  endfunction

  function automatic logic [psid_pkg::WORD_W-1:0] ps_word(input logic [9:0] xo,
      input logic [4:0] rd, input logic [4:0] ra, input logic [4:0] rb,
      input logic rc);
    return {psid_pkg::OP_PS, rd, ra, rb, xo, rc};
  endfunction

  function automatic psid_pkg::decode_t predict_decode(
      input logic [psid_pkg::WORD_W-1:0] w);
    psid_pkg::decode_t           r;
    logic [5:0]                  primary;
    logic [4:0]                  rd, ra, rb, rc;
    logic [9:0]                  xo10;
    logic [4:0]                  xo5;
    logic [psid_pkg::CODE_W-1:0] code;
    logic [psid_pkg::FORM_W-1:0] form;
    logic                        hit;
    r = '0;
    primary = w[31:26];
    rd = w[25:21];
    ra = w[20:16];
    rb = w[15:11];
    rc = w[10:6];
    xo10 = w[10:1];
    xo5 = w[5:1];
    code = '0;
    form = psid_pkg::FORM_NONE;
    if (primary == psid_pkg::OP_PSQ_L || primary == psid_pkg::OP_PSQ_LU ||
        primary == psid_pkg::OP_PSQ_ST || primary == psid_pkg::OP_PSQ_STU) begin
      case (primary)
        psid_pkg::OP_PSQ_L: r.insn_code = psid_pkg::I_PSQ_L;
        psid_pkg::OP_PSQ_LU: r.insn_code = psid_pkg::I_PSQ_LU;
        psid_pkg::OP_PSQ_ST: r.insn_code = psid_pkg::I_PSQ_ST;
        default: r.insn_code = psid_pkg::I_PSQ_STU;
      endcase
      r.recognized = 1'b1;
      r.operand_form = psid_pkg::FORM_QUANT;
      r.operand_count = 3'd4;
      r.operand_zero = rd;
      r.operand_one = ra;
      r.operand_two = {4'b0, w[15]};
      r.operand_three = {2'b0, w[14:12]};
      r.displacement = w[11:0];
      return r;
    end
    if (primary != psid_pkg::OP_PS)
      return r;
    hit = 1'b1;
    case (xo10)
      psid_pkg::XO_MERGE00: begin code = psid_pkg::I_MERGE00; form = psid_pkg::FORM_DAB; end
      psid_pkg::XO_MERGE01: begin code = psid_pkg::I_MERGE01; form = psid_pkg::FORM_DAB; end
      psid_pkg::XO_MERGE10: begin code = psid_pkg::I_MERGE10; form = psid_pkg::FORM_DAB; end
      psid_pkg::XO_MERGE11: begin code = psid_pkg::I_MERGE11; form = psid_pkg::FORM_DAB; end
      psid_pkg::XO_NEG: begin code = psid_pkg::I_NEG; form = psid_pkg::FORM_DB; end
      psid_pkg::XO_MR: begin code = psid_pkg::I_MR; form = psid_pkg::FORM_DB; end
      psid_pkg::XO_NABS: begin code = psid_pkg::I_NABS; form = psid_pkg::FORM_DB; end
      psid_pkg::XO_ABS: begin code = psid_pkg::I_ABS; form = psid_pkg::FORM_DB; end
      psid_pkg::XO_CMPU0, psid_pkg::XO_CMPO0, psid_pkg::XO_CMPU1, psid_pkg::XO_CMPO1: begin
        r.recognized = 1'b1;
        r.insn_code = psid_pkg::I_CMPU0 + {4'd0, xo10[6:5]};
        r.operand_form = psid_pkg::FORM_DAB;
        r.compare_form = 1'b1;
        r.operand_count = 3'd3;
        r.operand_zero = {2'b0, w[25:23]};
        r.operand_one = ra;
        r.operand_two = rb;
        return r;
      end
      default: hit = 1'b0;
    endcase
    if (!hit) begin
      hit = 1'b1;
      case (xo5)
        psid_pkg::XO_DIV: begin code = psid_pkg::I_DIV; form = psid_pkg::FORM_DAB; end
        psid_pkg::XO_SUB: begin code = psid_pkg::I_SUB; form = psid_pkg::FORM_DAB; end
        psid_pkg::XO_ADD: begin code = psid_pkg::I_ADD; form = psid_pkg::FORM_DAB; end
        psid_pkg::XO_RES: begin code = psid_pkg::I_RES; form = psid_pkg::FORM_DB; end
        psid_pkg::XO_RSQRTE: begin code = psid_pkg::I_RSQRTE; form = psid_pkg::FORM_DB; end
        psid_pkg::XO_MULS0: begin code = psid_pkg::I_MULS0; form = psid_pkg::FORM_DAC; end
        psid_pkg::XO_MULS1: begin code = psid_pkg::I_MULS1; form = psid_pkg::FORM_DAC; end
        psid_pkg::XO_MUL: begin code = psid_pkg::I_MUL; form = psid_pkg::FORM_DAC; end
        psid_pkg::XO_SUM0: begin code = psid_pkg::I_SUM0; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_SUM1: begin code = psid_pkg::I_SUM1; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_MADDS0: begin code = psid_pkg::I_MADDS0; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_MADDS1: begin code = psid_pkg::I_MADDS1; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_SEL: begin code = psid_pkg::I_SEL; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_MSUB: begin code = psid_pkg::I_MSUB; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_MADD: begin code = psid_pkg::I_MADD; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_NMSUB: begin code = psid_pkg::I_NMSUB; form = psid_pkg::FORM_DACB; end
        psid_pkg::XO_NMADD: begin code = psid_pkg::I_NMADD; form = psid_pkg::FORM_DACB; end
        default: hit = 1'b0;
      endcase
    end
    if (!hit)
      return r;
    r.recognized = 1'b1;
    r.insn_code = code;
    r.operand_form = form;
    r.operand_zero = rd;
    case (form)
      psid_pkg::FORM_DAB: begin
        r.operand_count = 3'd3;
        r.operand_one = ra;
        r.operand_two = rb;
      end
      psid_pkg::FORM_DAC: begin
        r.operand_count = 3'd3;
        r.operand_one = ra;
        r.operand_two = rc;
      end
      psid_pkg::FORM_DB: begin
        r.operand_count = 3'd2;
        r.operand_one = rb;
      end
      default: begin
        r.operand_count = 3'd4;
        r.operand_one = ra;
        r.operand_two = rc;
        r.operand_three = rb;
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [psid_pkg::WORD_W-1:0] w);
    while ($urandom_range(99) < sender_idle_pct) begin
      word_valid <= 1'b0;
      instruction_word <= $urandom();
      @(posedge clk);
    end
    word_valid <= 1'b1;
    instruction_word <= w;
    @(posedge clk);
    while (word_stall)
      @(posedge clk);
    pending_decodes.insert(pending_decodes.size(), predict_decode(w));
    words_sent++;
  endtask

  task automatic check_field(input string field, input longint exp_val,
      input longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst)
      result_stall <= 1'b0;
    else
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_decodes.size() == 0) begin
        $error("result transaction with no decode pending");
        mismatch_count++;
      end else begin
        want = pending_decodes.pop_front();
        results_seen++;
        if (want.recognized)
          recognised_seen++;
        check_field("recognized", want.recognized, recognized);
        check_field("insn_code", want.insn_code, insn_code);
        check_field("operand_form", want.operand_form, operand_form);
        check_field("compare_form", want.compare_form, compare_form);
        check_field("operand_count", want.operand_count, operand_count);
        check_field("operand_zero", want.operand_zero, operand_zero);
        check_field("operand_one", want.operand_one, operand_one);
        check_field("operand_two", want.operand_two, operand_two);
        check_field("operand_three", want.operand_three, operand_three);
        check_field("displacement", want.displacement, displacement);
      end
    end
  end

  task automatic test_quantized_memory();
    send_word(quant_word(quant_opcode(0), 5'd31, 5'd0, 1'b1, 3'd7, 12'h800));
    send_word(quant_word(quant_opcode(1), 5'd0, 5'd31, 1'b0, 3'd0, 12'h7FF));
    send_word(quant_word(quant_opcode(2), 5'd21, 5'd10, 1'b1, 3'd5, 12'hFFF));
    send_word(quant_word(quant_opcode(3), 5'd10, 5'd21, 1'b0, 3'd2, 12'h000));
  endtask

  // odd entries set the record bit and fD and fB to all ones; even entries set fA
  task automatic test_ten_bit_ops();
    for (int k = 0; k < 12; k++) begin
      if (k % 2 == 0)
        send_word(ps_word(ten_bit_opcode(k), 5'd0, 5'd31, 5'd0, 1'b0));
      else
        send_word(ps_word(ten_bit_opcode(k), 5'd31, 5'd0, 5'd31, 1'b1));
    end
  endtask

  task automatic test_five_bit_ops();
    for (int k = 0; k < 17; k++) begin
      if (k % 2 == 0)
        send_word(ps_word({5'd31, five_bit_opcode(k)}, 5'd0, 5'd31, 5'd0, 1'b1));
      else
        send_word(ps_word({5'd0, five_bit_opcode(k)}, 5'd31, 5'd0, 5'd31, 1'b0));
    end
  endtask

  task automatic test_unrecognised();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(ps_word(10'h3E0, 5'd31, 5'd31, 5'd31, 1'b1));
    send_word(ps_word(10'd16, 5'd7, 5'd9, 5'd11, 1'b0));
    send_word({6'd58, 26'h3FF_FFFF});
  endtask

  task automatic test_random_stream(input int count);
    int          sel;
    logic [31:0] r;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      r = $urandom();
      if (sel < 15)
        send_word({quant_opcode($urandom_range(3)), r[25:0]});
      else if (sel < 40)
        send_word(ps_word(ten_bit_opcode($urandom_range(11)), r[25:21], r[20:16],
                          r[15:11], r[0]));
      else if (sel < 75)
        send_word(ps_word({r[10:6], five_bit_opcode($urandom_range(16))}, r[25:21],
                          r[20:16], r[15:11], r[0]));
      else if (sel < 85)
        send_word({psid_pkg::OP_PS, r[25:0]});
      else
        send_word(r);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 25;
    receiver_stall_pct = 48;
    test_quantized_memory();
    test_ten_bit_ops();
    test_five_bit_ops();
    test_unrecognised();
    test_random_stream(700);
    sender_idle_pct = 48;
    receiver_stall_pct = 25;
    test_random_stream(700);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random_stream(600);
    word_valid <= 1'b0;
    while (pending_decodes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Decoded %0d words, %0d results checked, %0d of them recognised.",
             words_sent, results_seen, recognised_seen);
    $display("Covered quantized memory, all paired-single opcodes and raw words.");
    if (mismatch_count == 0)
      $display("PASS paired_single_insn_decoder_unit");
    else
      $display("FAIL paired_single_insn_decoder_unit");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL paired_single_insn_decoder_unit");
    $finish;
  end

endmodule

>>> paired_single_insn_decoder_unit.f
rtl/psid_pkg.sv
rtl/psid_decode.sv
rtl/paired_single_insn_decoder_unit.sv
tb/sv/tb_paired_single_insn_decoder_unit.sv
